>>> sv/ifhb_pkg.sv
// shared types, constants and helpers of the ipv4 fragment header builder
package ifhb_pkg;

  localparam logic [13:0] MTU_MIN   = 14'd68;
  localparam logic [13:0] MTU_MAX   = 14'd9000;
  localparam logic [13:0] HDR_BYTES = 14'd20;
  localparam logic [15:0] VER_IHL   = 16'h4500;
  localparam logic [15:0] TTL_WORD  = 16'h4000;
  localparam logic [15:0] FO_DF     = 16'h4000;
  localparam logic [15:0] FO_MF     = 16'h2000;
  localparam logic [15:0] IDENT_RST = 16'h0001;

  typedef enum logic [2:0] {
    REG_SOURCE  = 3'd0,
    REG_MASK    = 3'd1,
    REG_GATEWAY = 3'd2,
    REG_MTU     = 3'd3,
    REG_TOS     = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_DF    = 2'd1,
    ERR_FRAGS = 2'd2
  } err_t;

  typedef enum logic {
    BK_IDLE,
    BK_EMIT
  } bk_state_t;

  typedef struct packed {
    logic [31:0] source_address;
    logic [31:0] subnet_mask;
    logic [31:0] gateway_address;
    logic [13:0] link_mtu;
    logic [7:0]  service_type;
  } cfg_t;

  // one classified segment handed from front to back
  typedef struct packed {
    err_t        err;
    logic [15:0] len;
    logic        df;
    logic [31:0] hop;
    logic [15:0] sum;
  } seg_t;

  // data bytes per full fragment: clamped mtu minus header, whole 8-byte units
  function automatic logic [13:0] frag_block(input logic [13:0] mtu);
    logic [13:0] m;
    logic [13:0] b;
    if (mtu < MTU_MIN) begin
      m = MTU_MIN;
    end else if (mtu > MTU_MAX) begin
      m = MTU_MAX;
    end else begin
      m = mtu;
    end
    b = m - HDR_BYTES;
    return {b[13:3], 3'b000};
  endfunction

endpackage

>>> sv/ifhb_front.sv
// front end: takes a segment request, classifies errors, next hop and fixed header sum
module ifhb_front #(
  parameter int MAX_FRAGS = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  ifhb_pkg::cfg_t   cfg,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [15:0]      payload_length,
  input  logic [7:0]       upper_protocol,
  input  logic [31:0]      dest_address,
  input  logic             dont_fragment,
  output logic             push,
  input  logic             q_ready,
  output ifhb_pkg::seg_t   seg
);

  localparam int MW = $clog2(MAX_FRAGS + 1) + 14;
  localparam int CW = MW + 16;

  logic        f_valid;
  logic [15:0] f_len;
  logic [7:0]  f_proto;
  logic [31:0] f_dst;
  logic        f_df;

  logic [13:0]   blk;
  logic [MW-1:0] lim;
  logic          multi;
  logic          too_many;
  logic [18:0]   s;
  logic [16:0]   f1;
  logic [15:0]   f2;

  assign push     = f_valid && q_ready;
  assign in_ready = !f_valid || q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      f_valid <= 1'b1;
    end else if (push) begin
      f_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      f_len   <= payload_length;
      f_proto <= upper_protocol;
      f_dst   <= dest_address;
      f_df    <= dont_fragment;
    end
  end

  always_comb begin
    blk      = ifhb_pkg::frag_block(cfg.link_mtu);
    lim      = MW'(MAX_FRAGS) * MW'(blk);
    // more than one fragment iff length exceeds one block
    multi    = {2'b00, f_len} > {4'b0000, blk};
    too_many = CW'(f_len) > CW'(lim);

    // header words that stay fixed across the fragments of a segment
    s  = 19'(ifhb_pkg::VER_IHL | {8'h00, cfg.service_type})
       + 19'(ifhb_pkg::TTL_WORD | {8'h00, f_proto})
       + 19'(cfg.source_address[31:16]) + 19'(cfg.source_address[15:0])
       + 19'(f_dst[31:16]) + 19'(f_dst[15:0]);
    f1 = 17'(s[15:0]) + 17'(s[18:16]);
    f2 = f1[15:0] + 16'(f1[16]);

    if (f_df && multi) begin
      seg.err = ifhb_pkg::ERR_DF;
    end else if (too_many) begin
      seg.err = ifhb_pkg::ERR_FRAGS;
    end else begin
      seg.err = ifhb_pkg::ERR_NONE;
    end
    seg.len = f_len;
    seg.df  = f_df;
    seg.hop = ((cfg.source_address & cfg.subnet_mask) == (f_dst & cfg.subnet_mask))
            ? f_dst : cfg.gateway_address;
    seg.sum = f2;
  end

endmodule

>>> sv/ifhb_queue.sv
// two-entry queue of classified segments between front and back
module ifhb_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  ifhb_pkg::seg_t push_seg,
  output logic           q_ready,
  input  logic           pop,
  output logic           q_valid,
  output ifhb_pkg::seg_t head
);

  ifhb_pkg::seg_t mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign q_ready = count != 2'd2;
  assign q_valid = count != 2'd0;
  assign head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_seg;
    end
  end

endmodule

>>> sv/ifhb_back.sv
// back end: walks a segment one fragment per cycle into the output register while the output is not stalled
module ifhb_back (
  input  logic           clk,
  input  logic           rst,
  input  ifhb_pkg::cfg_t cfg,
  input  logic           q_valid,
  input  ifhb_pkg::seg_t head,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [13:0]    total_length,
  output logic [15:0]    flags_offset,
  output logic [15:0]    identification,
  output logic [15:0]    header_checksum,
  output logic [15:0]    payload_offset,
  output logic [31:0]    next_hop_address,
  output logic [1:0]     error_code,
  output logic           last_fragment
);

  ifhb_pkg::bk_state_t state;
  ifhb_pkg::bk_state_t state_next;
  ifhb_pkg::seg_t      cur;
  logic [15:0] rem;
  logic [15:0] rem_next;
  logic [15:0] off;
  logic [15:0] off_next;
  logic [15:0] ident;
  logic [15:0] ident_next;

  logic        advance;
  logic        emit;
  logic        load;
  logic [13:0] blk;
  logic        last;
  logic [13:0] data;
  logic [13:0] tlen;
  logic [15:0] fo;
  logic [17:0] s;
  logic [16:0] f1;
  logic [15:0] f2;
  logic        ov_next;

  always_comb begin
    blk     = ifhb_pkg::frag_block(cfg.link_mtu);
    advance = !out_valid || out_ready;
    last    = rem <= {2'b00, blk};
    data    = last ? rem[13:0] : blk;
    tlen    = data + ifhb_pkg::HDR_BYTES;
    if (cur.df) begin
      fo = ifhb_pkg::FO_DF;
    end else begin
      fo = {3'b000, off[15:3]} | (last ? 16'h0000 : ifhb_pkg::FO_MF);
    end
    s  = 18'(cur.sum) + 18'(tlen) + 18'(ident) + 18'(fo);
    f1 = 17'(s[15:0]) + 17'(s[17:16]);
    f2 = f1[15:0] + 16'(f1[16]);

    state_next = state;
    load       = 1'b0;
    emit       = 1'b0;
    pop        = 1'b0;
    rem_next   = rem;
    off_next   = off;
    ident_next = ident;
    ov_next    = out_valid && !out_ready;
    case (state)
      ifhb_pkg::BK_IDLE: begin
        if (q_valid) begin
          pop        = 1'b1;
          load       = 1'b1;
          rem_next   = head.len;
          off_next   = 16'h0000;
          state_next = ifhb_pkg::BK_EMIT;
        end
      end
      ifhb_pkg::BK_EMIT: begin
        if (advance) begin
          emit    = 1'b1;
          ov_next = 1'b1;
          if (cur.err != ifhb_pkg::ERR_NONE) begin
            state_next = ifhb_pkg::BK_IDLE;
          end else if (last) begin
            ident_next = ident + 16'd1;
            state_next = ifhb_pkg::BK_IDLE;
          end else begin
            rem_next = rem - {2'b00, blk};
            off_next = off + {2'b00, blk};
          end
        end
      end
      default: begin
        state_next = ifhb_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ifhb_pkg::BK_IDLE;
      ident     <= ifhb_pkg::IDENT_RST;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      ident     <= ident_next;
      out_valid <= ov_next;
    end
  end

  always_ff @(posedge clk) begin
    rem <= rem_next;
    off <= off_next;
    if (load) begin
      cur <= head;
    end
    if (emit) begin
      error_code    <= cur.err;
      last_fragment <= (cur.err != ifhb_pkg::ERR_NONE) || last;
      if (cur.err != ifhb_pkg::ERR_NONE) begin
        total_length     <= 14'd0;
        flags_offset     <= 16'h0000;
        identification   <= 16'h0000;
        header_checksum  <= 16'h0000;
        payload_offset   <= 16'h0000;
        next_hop_address <= 32'h0000_0000;
      end else begin
        total_length     <= tlen;
        flags_offset     <= fo;
        identification   <= ident;
        header_checksum  <= ~f2;
        payload_offset   <= off;
        next_hop_address <= cur.hop;
      end
    end
  end

endmodule

>>> sv/ipv4_fragment_header_builder.sv
// top level: interface registers, front classifier, segment queue and fragment emitter
// path of a request: front register, queue entry, segment register, output register
// throughput: one result per cycle while a segment is walked and the output is not
//   stalled; each segment is first popped and loaded in the idle state
// the front end takes a new request every cycle while the two-entry queue has room
// reset (synchronous, active high): queue empty, output invalid, identification 1,
//   registers to source 0, mask 255.255.255.0, gateway 0, mtu 1500, tos 0
module ipv4_fragment_header_builder #(
  parameter int MAX_FRAGS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] payload_length,
  input  logic [7:0]  upper_protocol,
  input  logic [31:0] dest_address,
  input  logic        dont_fragment,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [13:0] total_length,
  output logic [15:0] flags_offset,
  output logic [15:0] identification,
  output logic [15:0] header_checksum,
  output logic [15:0] payload_offset,
  output logic [31:0] next_hop_address,
  output logic [1:0]  error_code,
  output logic        last_fragment
);

  ifhb_pkg::cfg_t cfg;
  ifhb_pkg::seg_t push_seg;
  ifhb_pkg::seg_t head;
  logic push;
  logic q_ready;
  logic q_valid;
  logic pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.source_address  <= 32'h0000_0000;
      cfg.subnet_mask     <= 32'hFFFF_FF00;
      cfg.gateway_address <= 32'h0000_0000;
      cfg.link_mtu        <= 14'd1500;
      cfg.service_type    <= 8'h00;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ifhb_pkg::REG_SOURCE:  cfg.source_address  <= cfg_data;
        ifhb_pkg::REG_MASK:    cfg.subnet_mask     <= cfg_data;
        ifhb_pkg::REG_GATEWAY: cfg.gateway_address <= cfg_data;
        ifhb_pkg::REG_MTU:     cfg.link_mtu        <= cfg_data[13:0];
        ifhb_pkg::REG_TOS:     cfg.service_type    <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  ifhb_front #(
    .MAX_FRAGS(MAX_FRAGS)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .payload_length (payload_length),
    .upper_protocol (upper_protocol),
    .dest_address   (dest_address),
    .dont_fragment  (dont_fragment),
    .push           (push),
    .q_ready        (q_ready),
    .seg            (push_seg)
  );

  ifhb_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_seg (push_seg),
    .q_ready  (q_ready),
    .pop      (pop),
    .q_valid  (q_valid),
    .head     (head)
  );

  ifhb_back u_back (
    .clk              (clk),
    .rst              (rst),
    .cfg              (cfg),
    .q_valid          (q_valid),
    .head             (head),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .total_length     (total_length),
    .flags_offset     (flags_offset),
    .identification   (identification),
    .header_checksum  (header_checksum),
    .payload_offset   (payload_offset),
    .next_hop_address (next_hop_address),
    .error_code       (error_code),
    .last_fragment    (last_fragment)
  );

endmodule

>>> dv/tb_ipv4_fragment_header_builder.sv
// self-checking testbench for the ipv4 fragment header builder: directed and random segments
module tb_ipv4_fragment_header_builder;

  localparam int FRAG_LIMIT = 64;
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 20;
  localparam logic [15:0] OFFSET_MASK = 16'h1FFF;

  typedef struct packed {
    logic [15:0] payload_length;
    logic [7:0]  upper_protocol;
    logic [31:0] dest_address;
    logic        dont_fragment;
  } seg_req_t;

  typedef struct packed {
    logic [13:0]    total_length;
    logic [15:0]    flags_offset;
    logic [15:0]    identification;
    logic [15:0]    header_checksum;
    logic [15:0]    payload_offset;
    logic [31:0]    next_hop_address;
    ifhb_pkg::err_t error_code;
    logic           last_fragment;
  } frag_hdr_t;

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [15:0] payload_length;
  logic [7:0]  upper_protocol;
  logic [31:0] dest_address;
  logic        dont_fragment;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [13:0] total_length;
  logic [15:0] flags_offset;
  logic [15:0] identification;
  logic [15:0] header_checksum;
  logic [15:0] payload_offset;
  logic [31:0] next_hop_address;
  logic [1:0]  error_code;
  logic        last_fragment;

  // shadow of the block's registers and identification counter
  ifhb_pkg::cfg_t shadow_cfg;
  logic [15:0]    ident_next;
  frag_hdr_t      pending_headers[$];

  bit steady = 1'b0;
  int failures = 0;
  int segments_sent = 0;
  int headers_checked = 0;
  int error_results = 0;
  int reg_writes = 0;
  int idle_cycles = 0;

  ipv4_fragment_header_builder #(
    .MAX_FRAGS(FRAG_LIMIT)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .payload_length(payload_length),
    .upper_protocol(upper_protocol),
    .dest_address(dest_address),
    .dont_fragment(dont_fragment),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .total_length(total_length),
    .flags_offset(flags_offset),
    .identification(identification),
    .header_checksum(header_checksum),
    .payload_offset(payload_offset),
    .next_hop_address(next_hop_address),
    .error_code(error_code),
    .last_fragment(last_fragment)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned data_per_fragment(input logic [13:0] mtu);
    int unsigned m;
    m = mtu;
    if (m < ifhb_pkg::MTU_MIN) m = ifhb_pkg::MTU_MIN;
    if (m > ifhb_pkg::MTU_MAX) m = ifhb_pkg::MTU_MAX;
    return ((m - ifhb_pkg::HDR_BYTES) / 8) * 8;
  endfunction

  function automatic logic [15:0] header_checksum_of(input logic [13:0] tlen,
                                                     input logic [15:0] id,
                                                     input logic [15:0] fo,
                                                     input logic [7:0] proto,
                                                     input logic [31:0] dst);
    logic [31:0] acc;
    acc = (ifhb_pkg::VER_IHL | {8'h00, shadow_cfg.service_type}) + tlen + id + fo
        + (ifhb_pkg::TTL_WORD | {8'h00, proto})
        + shadow_cfg.source_address[31:16] + shadow_cfg.source_address[15:0]
        + dst[31:16] + dst[15:0];
    acc = acc[15:0] + acc[31:16];
    acc = acc[15:0] + acc[31:16];
    return ~acc[15:0];
  endfunction

  // expected headers of one accepted segment, in emission order
  task automatic predict_fragments(input seg_req_t s);
    int unsigned block, nfrag, off, data, len;
    logic [15:0] fo;
    logic [31:0] hop;
    logic        last;
    frag_hdr_t   h;
    len = s.payload_length;
    block = data_per_fragment(shadow_cfg.link_mtu);
    nfrag = (len == 0) ? 1 : (len + block - 1) / block;
    if ((s.dont_fragment && nfrag > 1) || nfrag > FRAG_LIMIT) begin
      h = '0;
      h.error_code = (s.dont_fragment && nfrag > 1) ? ifhb_pkg::ERR_DF
                                                    : ifhb_pkg::ERR_FRAGS;
      h.last_fragment = 1'b1;
      pending_headers.push_back(h);
      return;
    end
    hop = ((shadow_cfg.source_address & shadow_cfg.subnet_mask) ==
           (s.dest_address & shadow_cfg.subnet_mask)) ? s.dest_address
                                                       : shadow_cfg.gateway_address;
    for (int unsigned i = 0; i < nfrag; i++) begin
      off = i * block;
      last = (i + 1 == nfrag);
      data = last ? len - off : block;
      if (s.dont_fragment) begin
        fo = ifhb_pkg::FO_DF;
      end else begin
        fo = (16'(off / 8) & OFFSET_MASK) | (last ? 16'h0000 : ifhb_pkg::FO_MF);
      end
      h.total_length = 14'(data + ifhb_pkg::HDR_BYTES);
      h.flags_offset = fo;
      h.identification = ident_next;
      h.header_checksum = header_checksum_of(h.total_length, ident_next, fo,
                                             s.upper_protocol, s.dest_address);
      h.payload_offset = 16'(off);
      h.next_hop_address = hop;
      h.error_code = ifhb_pkg::ERR_NONE;
      h.last_fragment = last;
      pending_headers.push_back(h);
    end
    ident_next = ident_next + 16'd1;
  endtask

  task automatic log_failure(input string msg);
    failures++;
    if (failures <= 10) $display("%s", msg);
  endtask

  task automatic send_segment(input logic [15:0] len, input logic [7:0] proto,
                              input logic [31:0] dst, input logic df);
    seg_req_t s;
    s.payload_length = len;
    s.upper_protocol = proto;
    s.dest_address = dst;
    s.dont_fragment = df;
    if (!steady) begin
      while ($urandom_range(0, 99) < 16) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    payload_length <= len;
    upper_protocol <= proto;
    dest_address <= dst;
    dont_fragment <= df;
    do @(posedge clk); while (!in_ready);
    predict_fragments(s);
    segments_sent++;
  endtask

  task automatic write_register(input ifhb_pkg::reg_idx_t idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      ifhb_pkg::REG_SOURCE:  shadow_cfg.source_address = data;
      ifhb_pkg::REG_MASK:    shadow_cfg.subnet_mask = data;
      ifhb_pkg::REG_GATEWAY: shadow_cfg.gateway_address = data;
      ifhb_pkg::REG_MTU:     shadow_cfg.link_mtu = data[13:0];
      ifhb_pkg::REG_TOS:     shadow_cfg.service_type = data[7:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  // upper bits of the narrow registers carry junk that must be dropped
  task automatic program_registers(input logic [31:0] src, input logic [31:0] mask,
                                   input logic [31:0] gw, input logic [13:0] mtu,
                                   input logic [7:0] tos);
    logic [31:0] junk;
    junk = $urandom;
    write_register(ifhb_pkg::REG_SOURCE, src);
    write_register(ifhb_pkg::REG_MASK, mask);
    write_register(ifhb_pkg::REG_GATEWAY, gw);
    write_register(ifhb_pkg::REG_MTU, {junk[31:14], mtu});
    write_register(ifhb_pkg::REG_TOS, {junk[31:8], tos});
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_headers.size() != 0) @(posedge clk);
  endtask

  task automatic test_power_on_settings();
    send_segment(16'd0, 8'd17, 32'h0000_0001, 1'b0);
    send_segment(16'd1480, 8'd6, 32'hC0A8_0101, 1'b0);
    send_segment(16'd1481, 8'd255, 32'h0000_00FE, 1'b0);
    send_segment(16'd2960, 8'd0, 32'hFFFF_FFFF, 1'b0);
    send_segment(16'hFFFF, 8'd1, 32'h0000_0000, 1'b0);
    wait_drained();
  endtask

  // smallest mtu: 48 data bytes per fragment, so the fragment limit is reachable
  task automatic test_fragment_limits();
    program_registers(32'hC0A8_0001, 32'hFFFF_FF00, 32'hC0A8_00FE, ifhb_pkg::MTU_MIN,
                      8'hB8);
    send_segment(16'd3072, 8'd17, 32'hC0A8_000A, 1'b0);
    send_segment(16'd3073, 8'd17, 32'hC0A8_000A, 1'b0);
    send_segment(16'd48, 8'd6, 32'h0808_0808, 1'b1);
    send_segment(16'd49, 8'd6, 32'h0808_0808, 1'b1);
    send_segment(16'hFFFF, 8'd255, 32'hC0A8_0014, 1'b1);
    send_segment(16'd0, 8'd0, 32'hC0A8_0014, 1'b1);
    send_segment(16'hFFFF, 8'd0, 32'h0808_0808, 1'b0);
    wait_drained();
  endtask

  task automatic test_mtu_clamp();
    program_registers(32'h0A00_0001, 32'hFF00_0000, 32'h0A00_0002, 14'd0, 8'h10);
    send_segment(16'd49, 8'd17, 32'h0A01_0203, 1'b0);
    wait_drained();
    program_registers(32'h0A00_0001, 32'hFF00_0000, 32'h0A00_0002, 14'h3FFF, 8'h10);
    send_segment(16'hFFFF, 8'd6, 32'h0B01_0203, 1'b0);
    send_segment(16'd8976, 8'd6, 32'h0A01_0203, 1'b1);
    wait_drained();
    program_registers(32'h0A00_0001, 32'hFF00_0000, 32'h0A00_0002, 14'd1501, 8'h10);
    send_segment(16'd2961, 8'd132, 32'h0A7F_FFFF, 1'b0);
    wait_drained();
    program_registers(32'h0A00_0001, 32'hFF00_0000, 32'h0A00_0002, 14'd9001, 8'h10);
    send_segment(16'd8977, 8'd50, 32'h0A00_0001, 1'b0);
    wait_drained();
  endtask

  task automatic test_next_hop();
    program_registers(32'hFFFF_FFFF, 32'h0000_0000, 32'h1234_5678, 14'd1500, 8'hFF);
    send_segment(16'd100, 8'd17, 32'h0102_0304, 1'b0);
    wait_drained();
    program_registers(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1234_5678, 14'd1500, 8'hFF);
    send_segment(16'd100, 8'd17, 32'hFFFF_FFFF, 1'b0);
    send_segment(16'd100, 8'd17, 32'hFFFF_FFFE, 1'b0);
    send_segment(16'd3000, 8'd1, 32'h0000_0000, 1'b0);
    wait_drained();
  endtask

  task automatic random_segment();
    int unsigned block, span, len;
    logic        df;
    logic [31:0] dst;
    block = data_per_fragment(shadow_cfg.link_mtu);
    span = block * FRAG_LIMIT;
    if (span > 65535) span = 65535;
    case ($urandom_range(0, 9))
      0, 1: len = $urandom_range(0, 65535);
      // around whole multiples of the fragment size
      2, 3: begin
        len = block * $urandom_range(1, FRAG_LIMIT) + $urandom_range(0, 2) - 1;
        if (len > 65535) len = 65535;
      end
      default: len = $urandom_range(0, span);
    endcase
    df = ($urandom_range(0, 99) < 20);
    if (df && $urandom_range(0, 1)) len = $urandom_range(0, block + 1);
    if ($urandom_range(0, 1)) begin
      dst = (shadow_cfg.source_address & shadow_cfg.subnet_mask) |
            ($urandom & ~shadow_cfg.subnet_mask);
    end else begin
      dst = $urandom;
    end
    send_segment(16'(len), 8'($urandom), dst, df);
  endtask

  task automatic test_random_traffic();
    logic [31:0] src, mask, gw;
    logic [13:0] mtu;
    for (int phase = 0; phase < 5; phase++) begin
      src = $urandom;
      gw = $urandom;
      case ($urandom_range(0, 3))
        0: mask = '0;
        1: mask = '1;
        default: mask = 32'hFFFF_FFFF << $urandom_range(1, 31);
      endcase
      case ($urandom_range(0, 7))
        0: mtu = 14'd0;
        1: mtu = 14'd67;
        2: mtu = 14'd69;
        3: mtu = 14'd576;
        4: mtu = 14'd1501;
        5: mtu = 14'd9001;
        6: mtu = 14'h3FFF;
        default: mtu = 14'($urandom_range(68, 9000));
      endcase
      if (phase == 0) mtu = ifhb_pkg::MTU_MIN;
      if (phase == 1) mtu = ifhb_pkg::MTU_MAX;
      // one phase runs with both sides streaming
      steady = (phase == 3);
      program_registers(src, mask, gw, mtu, 8'($urandom));
      repeat (22) random_segment();
      wait_drained();
    end
    steady = 1'b0;
  endtask

  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= 16);
  end

  always @(posedge clk) begin : check_headers
    frag_hdr_t got;
    frag_hdr_t want;
    string     bad;
    if (!rst && out_valid && out_ready) begin
      got.total_length = total_length;
      got.flags_offset = flags_offset;
      got.identification = identification;
      got.header_checksum = header_checksum;
      got.payload_offset = payload_offset;
      got.next_hop_address = next_hop_address;
      got.error_code = ifhb_pkg::err_t'(error_code);
      got.last_fragment = last_fragment;
      if (pending_headers.size() == 0) begin
        log_failure($sformatf("unexpected header at %0t: len %0d fo %h err %0d",
                              $time, got.total_length, got.flags_offset,
                              got.error_code));
      end else begin
        want = pending_headers.pop_front();
        headers_checked++;
        if (want.error_code != ifhb_pkg::ERR_NONE) error_results++;
        bad = "";
        if (got.total_length !== want.total_length) bad = {bad, " total_length"};
        if (got.flags_offset !== want.flags_offset) bad = {bad, " flags_offset"};
        if (got.identification !== want.identification) bad = {bad, " identification"};
        if (got.header_checksum !== want.header_checksum) bad = {bad, " header_checksum"};
        if (got.payload_offset !== want.payload_offset) bad = {bad, " payload_offset"};
        if (got.next_hop_address !== want.next_hop_address) bad = {bad, " next_hop_address"};
        if (got.error_code !== want.error_code) bad = {bad, " error_code"};
        if (got.last_fragment !== want.last_fragment) bad = {bad, " last_fragment"};
        if (bad != "") begin
          log_failure($sformatf({"mismatch at %0t in%s: expected len %0d fo %h id %h ",
                                 "sum %h off %0d hop %h err %0d last %0b, got len %0d ",
                                 "fo %h id %h sum %h off %0d hop %h err %0d last %0b"},
                                $time, bad, want.total_length, want.flags_offset,
                                want.identification, want.header_checksum,
                                want.payload_offset, want.next_hop_address,
                                want.error_code, want.last_fragment, got.total_length,
                                got.flags_offset, got.identification,
                                got.header_checksum, got.payload_offset,
                                got.next_hop_address, got.error_code,
                                got.last_fragment));
        end
      end
    end
  end

  // cycles without any accepted request or result
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("timeout: no progress for %0d cycles", STALL_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    rst <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_index <= ifhb_pkg::REG_SOURCE;
    cfg_data <= '0;
    in_valid <= 1'b0;
    payload_length <= '0;
    upper_protocol <= '0;
    dest_address <= '0;
    dont_fragment <= 1'b0;
    shadow_cfg.source_address = '0;
    shadow_cfg.subnet_mask = 32'hFFFF_FF00;
    shadow_cfg.gateway_address = '0;
    shadow_cfg.link_mtu = 14'd1500;
    shadow_cfg.service_type = '0;
    ident_next = ifhb_pkg::IDENT_RST;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_power_on_settings();
    test_fragment_limits();
    test_mtu_clamp();
    test_next_hop();
    test_random_traffic();

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d segments and %0d register writes over mtu, mask and df extremes",
             segments_sent, reg_writes);
    $display("checked %0d headers, %0d of them error results; %0d failures",
             headers_checked, error_results, failures);
    if (failures == 0 && pending_headers.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
